[src/gdtt_pkg.sv]
// gdtt_pkg: shared constants, bit codes and the result type of the double-tap tracker
// no dependencies; used by gamepad_double_tap_tracker_unit, gdtt_checker and the bench
`default_nettype none

package gdtt_pkg;

    parameter int PORT_COUNT_DEF = 4;
    parameter int STAMP_BITS_DEF = 16;

    parameter int PORT_W   = 3;
    parameter int MASK_W   = 12;
    parameter int FRAME_W  = 16;
    parameter int WINDOW_W = 16;
    parameter int KEY_W    = 8;
    parameter int ARROW_W  = 4;

    parameter logic [WINDOW_W-1:0] WINDOW_RESET = 16'd30;

    // button bit positions in the change and level masks
    parameter logic [2:0] POS_UP    = 3'd0;
    parameter logic [2:0] POS_DOWN  = 3'd1;
    parameter logic [2:0] POS_LEFT  = 3'd2;
    parameter logic [2:0] POS_RIGHT = 3'd3;
    parameter logic [2:0] POS_B     = 3'd4;
    parameter logic [2:0] POS_C     = 3'd5;
    parameter logic [2:0] POS_A     = 3'd6;
    parameter logic [2:0] POS_START = 3'd7;

    parameter logic [KEY_W-1:0] START_ONLY = 8'h80;

    // double-tap flag positions
    parameter logic FLAG_X = 1'b0;
    parameter logic FLAG_Y = 1'b1;

    typedef struct packed {
        logic                 accepted;
        logic [KEY_W-1:0]     held_key_mask;
        logic [ARROW_W-1:0]   held_arrow_mask;
        logic [ARROW_W-1:0]   last_arrow_mask;
        logic                 double_tap_x;
        logic                 double_tap_y;
        logic [FRAME_W-1:0]   key_press_frame;
        logic [FRAME_W-1:0]   key_release_frame;
    } res_t;

endpackage

`default_nettype wire

[src/gamepad_double_tap_tracker_unit.sv]
// gamepad_double_tap_tracker_unit: per-port controller record with double-tap detection
// depends on gdtt_pkg for constants and the result type
`default_nettype none

// Takes one controller change event per clock while in_stall is low and answers each
// with the updated record of its port. Records live in a small synchronous memory: the
// port is read on the edge that accepts the request, then the update stage applies keys
// then arrows (down, up, left, right) once the result queue has room, writes the record
// back and queues the result. Back-to-back requests to the same port take the record
// from a bypass register instead of the memory. A two-entry result queue lets requests
// keep flowing while out_stall holds a result; in_stall rises only when the queue is
// full and the update stage is occupied.
// Ports at or above PORT_COUNT leave all records alone and answer with all zeros.
module gamepad_double_tap_tracker_unit #(
    parameter int PORT_COUNT = gdtt_pkg::PORT_COUNT_DEF,
    parameter int STAMP_BITS = gdtt_pkg::STAMP_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [gdtt_pkg::WINDOW_W-1:0]  cfg_wdata,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [gdtt_pkg::PORT_W-1:0]    port,
    input  wire logic [gdtt_pkg::MASK_W-1:0]    changed_mask,
    input  wire logic [gdtt_pkg::MASK_W-1:0]    pressed_mask,
    input  wire logic [gdtt_pkg::FRAME_W-1:0]   frame_now,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic                                accepted,
    output logic [gdtt_pkg::KEY_W-1:0]          held_key_mask,
    output logic [gdtt_pkg::ARROW_W-1:0]        held_arrow_mask,
    output logic [gdtt_pkg::ARROW_W-1:0]        last_arrow_mask,
    output logic                                double_tap_x,
    output logic                                double_tap_y,
    output logic [gdtt_pkg::FRAME_W-1:0]        key_press_frame,
    output logic [gdtt_pkg::FRAME_W-1:0]        key_release_frame
);

    localparam int IDX_W = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
    localparam int CMP_W = (STAMP_BITS > gdtt_pkg::WINDOW_W) ? STAMP_BITS : gdtt_pkg::WINDOW_W;
    localparam int KEY_W = gdtt_pkg::KEY_W;
    localparam int ARROW_W = gdtt_pkg::ARROW_W;

    localparam logic [2:0] KEY_ORDER [3] = '{gdtt_pkg::POS_A, gdtt_pkg::POS_B,
                                             gdtt_pkg::POS_C};
    localparam logic [1:0] ARROW_ORDER [4] = '{gdtt_pkg::POS_DOWN[1:0], gdtt_pkg::POS_UP[1:0],
                                               gdtt_pkg::POS_LEFT[1:0],
                                               gdtt_pkg::POS_RIGHT[1:0]};
    localparam logic ARROW_FLAG [4] = '{gdtt_pkg::FLAG_Y, gdtt_pkg::FLAG_Y,
                                        gdtt_pkg::FLAG_X, gdtt_pkg::FLAG_X};

    typedef struct packed {
        logic [KEY_W-1:0]      keys;
        logic [ARROW_W-1:0]    arrows;
        logic [ARROW_W-1:0]    last;
        logic [STAMP_BITS-1:0] kp;
        logic [STAMP_BITS-1:0] kr;
        logic [STAMP_BITS-1:0] ap;
        logic [STAMP_BITS-1:0] ar;
        logic [1:0]            flags;
    } rec_t;

    // configuration
    logic [gdtt_pkg::WINDOW_W-1:0] window_reg;

    // update stage
    logic                          s1_valid_reg, s1_valid_next;
    logic [gdtt_pkg::PORT_W-1:0]   s1_port_reg;
    logic [KEY_W-1:0]              s1_chg_reg;
    logic [KEY_W-1:0]              s1_lvl_reg;
    logic [STAMP_BITS-1:0]         s1_now_reg;

    // record memory and bypass
    rec_t                          mem [PORT_COUNT];
    logic [PORT_COUNT-1:0]         vld_reg;
    rec_t                          rd_rec_reg;
    logic                          rd_vld_reg;
    logic                          fwd_sel_reg;
    rec_t                          fwd_rec_reg;

    // result queue
    gdtt_pkg::res_t                q_reg [2];
    logic                          wr_ptr_reg;
    logic                          rd_ptr_reg;
    logic [1:0]                    cnt_reg;

    logic                          in_accept;
    logic                          s1_go;
    logic                          pop;
    logic                          s1_tracked;
    logic [IDX_W-1:0]              s1_idx;
    logic [IDX_W-1:0]              in_idx;
    rec_t                          cur_rec;
    rec_t                          new_rec;
    gdtt_pkg::res_t                new_res;
    logic [STAMP_BITS-1:0]         hold;
    logic [STAMP_BITS-1:0]         gap;

    assign s1_go     = s1_valid_reg && (cnt_reg != 2'd2);
    assign in_stall  = s1_valid_reg && (cnt_reg == 2'd2);
    assign in_accept = in_valid && !in_stall;
    assign out_valid = (cnt_reg != 2'd0);
    assign pop       = out_valid && !out_stall;

    assign s1_tracked = ({1'b0, s1_port_reg} < (gdtt_pkg::PORT_W + 1)'(PORT_COUNT));
    assign s1_idx     = s1_port_reg[IDX_W-1:0];
    assign in_idx     = port[IDX_W-1:0];

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg   <= gdtt_pkg::WINDOW_RESET;
            s1_valid_reg <= 1'b0;
            vld_reg      <= '0;
            fwd_sel_reg  <= 1'b0;
            wr_ptr_reg   <= 1'b0;
            rd_ptr_reg   <= 1'b0;
            cnt_reg      <= 2'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                window_reg <= cfg_wdata;
            end
            s1_valid_reg <= s1_valid_next;
            if (s1_go && s1_tracked)
            begin
                vld_reg[s1_idx] <= 1'b1;
            end
            if (in_accept)
            begin
                // the write below lands on the same edge as this read
                fwd_sel_reg <= s1_go && s1_tracked && (s1_port_reg == port);
            end
            if (s1_go)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, s1_go} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_port_reg <= port;
            s1_chg_reg  <= changed_mask[KEY_W-1:0];
            s1_lvl_reg  <= pressed_mask[KEY_W-1:0];
            s1_now_reg  <= STAMP_BITS'(frame_now);
            rd_vld_reg  <= vld_reg[in_idx];
            fwd_rec_reg <= new_rec;
        end
        if (s1_go)
        begin
            q_reg[wr_ptr_reg] <= new_res;
        end
    end

    // record memory
    always_ff @(posedge clk)
    begin
        if (s1_go && s1_tracked)
        begin
            mem[s1_idx] <= new_rec;
        end
        if (in_accept)
        begin
            rd_rec_reg <= mem[in_idx];
        end
    end

    always_comb
    begin
        if (fwd_sel_reg)
        begin
            cur_rec = fwd_rec_reg;
        end
        else if (rd_vld_reg)
        begin
            cur_rec = rd_rec_reg;
        end
        else
        begin
            cur_rec = '0;
        end
    end

    always_comb
    begin
        new_rec = cur_rec;
        hold    = '0;
        gap     = '0;
        for (int k = 0; k < 3; k++)
        begin
            if (s1_chg_reg[KEY_ORDER[k]])
            begin
                if (s1_lvl_reg[KEY_ORDER[k]])
                begin
                    new_rec.keys[KEY_ORDER[k]] = 1'b1;
                    new_rec.kp = s1_now_reg;
                end
                else
                begin
                    new_rec.keys[KEY_ORDER[k]] = 1'b0;
                    new_rec.kr = s1_now_reg;
                end
            end
        end
        if (s1_chg_reg[gdtt_pkg::POS_START])
        begin
            if (s1_lvl_reg[gdtt_pkg::POS_START])
            begin
                new_rec.keys = gdtt_pkg::START_ONLY;
                new_rec.kp   = s1_now_reg;
            end
            else
            begin
                new_rec.keys[gdtt_pkg::POS_START] = 1'b0;
                new_rec.kr = s1_now_reg;
            end
        end
        for (int a = 0; a < 4; a++)
        begin
            if (s1_chg_reg[{1'b0, ARROW_ORDER[a]}])
            begin
                if (s1_lvl_reg[{1'b0, ARROW_ORDER[a]}])
                begin
                    hold = new_rec.ar - new_rec.ap;
                    gap  = s1_now_reg - new_rec.ar;
                    if ((new_rec.last == (ARROW_W'(1) << ARROW_ORDER[a]))
                        && (CMP_W'(hold) < CMP_W'(window_reg))
                        && (CMP_W'(gap) < CMP_W'(window_reg)))
                    begin
                        new_rec.flags[ARROW_FLAG[a]] = 1'b1;
                    end
                    new_rec.arrows[ARROW_ORDER[a]] = 1'b1;
                    new_rec.ap = s1_now_reg;
                end
                else
                begin
                    new_rec.ar = s1_now_reg;
                    new_rec.arrows[ARROW_ORDER[a]] = 1'b0;
                    new_rec.last = ARROW_W'(1) << ARROW_ORDER[a];
                    new_rec.flags[ARROW_FLAG[a]] = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        new_res = '0;
        if (s1_tracked)
        begin
            new_res.accepted          = 1'b1;
            new_res.held_key_mask     = new_rec.keys;
            new_res.held_arrow_mask   = new_rec.arrows;
            new_res.last_arrow_mask   = new_rec.last;
            new_res.double_tap_x      = new_rec.flags[gdtt_pkg::FLAG_X];
            new_res.double_tap_y      = new_rec.flags[gdtt_pkg::FLAG_Y];
            new_res.key_press_frame   = gdtt_pkg::FRAME_W'(new_rec.kp);
            new_res.key_release_frame = gdtt_pkg::FRAME_W'(new_rec.kr);
        end
    end

    assign accepted          = q_reg[rd_ptr_reg].accepted;
    assign held_key_mask     = q_reg[rd_ptr_reg].held_key_mask;
    assign held_arrow_mask   = q_reg[rd_ptr_reg].held_arrow_mask;
    assign last_arrow_mask   = q_reg[rd_ptr_reg].last_arrow_mask;
    assign double_tap_x      = q_reg[rd_ptr_reg].double_tap_x;
    assign double_tap_y      = q_reg[rd_ptr_reg].double_tap_y;
    assign key_press_frame   = q_reg[rd_ptr_reg].key_press_frame;
    assign key_release_frame = q_reg[rd_ptr_reg].key_release_frame;

endmodule

`default_nettype wire

[src/gdtt_checker.sv]
// gdtt_checker: port-level assertions for gamepad_double_tap_tracker_unit, plus its bind
// depends on gdtt_pkg for field widths
`default_nettype none

module gdtt_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          out_valid,
    input wire logic                          out_stall,
    input wire logic                          accepted,
    input wire logic [gdtt_pkg::KEY_W-1:0]    held_key_mask,
    input wire logic [gdtt_pkg::ARROW_W-1:0]  held_arrow_mask,
    input wire logic [gdtt_pkg::ARROW_W-1:0]  last_arrow_mask,
    input wire logic                          double_tap_x,
    input wire logic                          double_tap_y,
    input wire logic [gdtt_pkg::FRAME_W-1:0]  key_press_frame,
    input wire logic [gdtt_pkg::FRAME_W-1:0]  key_release_frame
);

    // a stalled result stays offered with its key mask, press frame and accepted bit unchanged
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(held_key_mask)
            && $stable(key_press_frame) && $stable(accepted))
        else $error("stalled result changed");

    // untracked port answers with an all-zero record
    a_untracked_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !accepted |-> held_key_mask == '0 && held_arrow_mask == '0
            && last_arrow_mask == '0 && !double_tap_x && !double_tap_y
            && key_press_frame == '0 && key_release_frame == '0)
        else $error("untracked request returned a nonzero record");

    // arrow bits never leak into the key mask, last arrow has at most one bit set
    a_record_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> held_key_mask[3:0] == 4'd0 && $onehot0(last_arrow_mask))
        else $error("malformed key mask or last arrow");

    // an active double tap means an arrow on that axis is still held
    a_flag_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!double_tap_x || held_arrow_mask[2] || held_arrow_mask[3])
            && (!double_tap_y || held_arrow_mask[0] || held_arrow_mask[1]))
        else $error("double-tap flag without a held arrow");

endmodule

bind gamepad_double_tap_tracker_unit gdtt_checker u_gdtt_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .accepted          (accepted),
    .held_key_mask     (held_key_mask),
    .held_arrow_mask   (held_arrow_mask),
    .last_arrow_mask   (last_arrow_mask),
    .double_tap_x      (double_tap_x),
    .double_tap_y      (double_tap_y),
    .key_press_frame   (key_press_frame),
    .key_release_frame (key_release_frame)
);

`default_nettype wire

[tb/sv/gamepad_double_tap_tracker_unit_tb.sv]
// gamepad_double_tap_tracker_unit_tb: self-checking bench for the double-tap tracker,
// with a per-port record predictor, directed table, random tap sequences and stall pressure
// depends on gdtt_pkg and gamepad_double_tap_tracker_unit
module gamepad_double_tap_tracker_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gdtt_pkg::*;

    localparam int TRACKED_PORTS = PORT_COUNT_DEF;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_CYCLES   = 80;

    typedef struct {
        logic [PORT_W-1:0]  prt;
        logic [MASK_W-1:0]  chg;
        logic [MASK_W-1:0]  lvl;
        logic [FRAME_W-1:0] frm;
        bit                 typed;
        res_t               want;
    } stim_row_t;

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [WINDOW_W-1:0] cfg_wdata = '0;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    logic [PORT_W-1:0]   ev_port    = '0;
    logic [MASK_W-1:0]   ev_changed = '0;
    logic [MASK_W-1:0]   ev_pressed = '0;
    logic [FRAME_W-1:0]  ev_frame   = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic                rec_accepted;
    logic [KEY_W-1:0]    rec_keys;
    logic [ARROW_W-1:0]  rec_arrows;
    logic [ARROW_W-1:0]  rec_last_arrow;
    logic                rec_tap_x;
    logic                rec_tap_y;
    logic [FRAME_W-1:0]  rec_press_frame;
    logic [FRAME_W-1:0]  rec_release_frame;

    // predictor copy of the per-port records and the window register
    logic [WINDOW_W-1:0] window_reg;
    logic [KEY_W-1:0]    keys_st     [TRACKED_PORTS];
    logic [ARROW_W-1:0]  arrows_st   [TRACKED_PORTS];
    logic [ARROW_W-1:0]  last_rel_st [TRACKED_PORTS];
    logic [FRAME_W-1:0]  key_press_st   [TRACKED_PORTS];
    logic [FRAME_W-1:0]  key_release_st [TRACKED_PORTS];
    logic [FRAME_W-1:0]  arr_press_st   [TRACKED_PORTS];
    logic [FRAME_W-1:0]  arr_release_st [TRACKED_PORTS];
    logic [1:0]          flags_st    [TRACKED_PORTS];

    res_t expected_records[$];
    int   mismatch_count = 0;
    int   cycle_count = 0;
    bit   calm = 1'b0;
    bit   hold_req = 1'b0;

    gamepad_double_tap_tracker_unit dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .port              (ev_port),
        .changed_mask      (ev_changed),
        .pressed_mask      (ev_pressed),
        .frame_now         (ev_frame),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .accepted          (rec_accepted),
        .held_key_mask     (rec_keys),
        .held_arrow_mask   (rec_arrows),
        .last_arrow_mask   (rec_last_arrow),
        .double_tap_x      (rec_tap_x),
        .double_tap_y      (rec_tap_y),
        .key_press_frame   (rec_press_frame),
        .key_release_frame (rec_release_frame)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic res_t predict_event(input logic [PORT_W-1:0] p_in,
                                           input logic [MASK_W-1:0] chg,
                                           input logic [MASK_W-1:0] lvl,
                                           input logic [FRAME_W-1:0] now);
        res_t               r;
        int                 p;
        logic [2:0]         key_order [4];
        logic [2:0]         arrow_order [4];
        logic               axis_of [4];
        logic [2:0]         pos;
        logic [ARROW_W-1:0] abit;
        logic [FRAME_W-1:0] held_for;
        logic [FRAME_W-1:0] gap;
        r = '0;
        key_order   = '{POS_A, POS_B, POS_C, POS_START};
        arrow_order = '{POS_DOWN, POS_UP, POS_LEFT, POS_RIGHT};
        axis_of     = '{FLAG_Y, FLAG_Y, FLAG_X, FLAG_X};
        if (p_in < TRACKED_PORTS)
        begin
            p = p_in;
            for (int k = 0; k < 4; k++)
            begin
                pos = key_order[k];
                if (chg[{1'b0, pos}])
                begin
                    if (lvl[{1'b0, pos}])
                    begin
                        if (pos == POS_START)
                            keys_st[p] = START_ONLY;
                        else
                            keys_st[p][pos] = 1'b1;
                        key_press_st[p] = now;
                    end
                    else
                    begin
                        key_release_st[p] = now;
                        keys_st[p][pos] = 1'b0;
                    end
                end
            end
            for (int k = 0; k < 4; k++)
            begin
                pos = arrow_order[k];
                abit = ARROW_W'(1) << pos;
                if (chg[{1'b0, pos}])
                begin
                    if (lvl[{1'b0, pos}])
                    begin
                        held_for = arr_release_st[p] - arr_press_st[p];
                        gap = now - arr_release_st[p];
                        if (last_rel_st[p] == abit && held_for < window_reg && gap < window_reg)
                            flags_st[p][axis_of[k]] = 1'b1;
                        arrows_st[p][pos[1:0]] = 1'b1;
                        arr_press_st[p] = now;
                    end
                    else
                    begin
                        arr_release_st[p] = now;
                        arrows_st[p][pos[1:0]] = 1'b0;
                        last_rel_st[p] = abit;
                        flags_st[p][axis_of[k]] = 1'b0;
                    end
                end
            end
            r.accepted          = 1'b1;
            r.held_key_mask     = keys_st[p];
            r.held_arrow_mask   = arrows_st[p];
            r.last_arrow_mask   = last_rel_st[p];
            r.double_tap_x      = flags_st[p][FLAG_X];
            r.double_tap_y      = flags_st[p][FLAG_Y];
            r.key_press_frame   = key_press_st[p];
            r.key_release_frame = key_release_st[p];
        end
        return r;
    endfunction

    function automatic res_t mk_res(input logic acc, input logic [KEY_W-1:0] keys,
                                    input logic [ARROW_W-1:0] arrows, last,
                                    input logic tx, ty, input logic [FRAME_W-1:0] kp, kr);
        res_t r;
        r.accepted          = acc;
        r.held_key_mask     = keys;
        r.held_arrow_mask   = arrows;
        r.last_arrow_mask   = last;
        r.double_tap_x      = tx;
        r.double_tap_y      = ty;
        r.key_press_frame   = kp;
        r.key_release_frame = kr;
        return r;
    endfunction

    function automatic stim_row_t row_of(input logic [PORT_W-1:0] p, input logic [MASK_W-1:0] c,
                                         input logic [MASK_W-1:0] l, input logic [FRAME_W-1:0] f,
                                         input bit typed, input res_t want);
        stim_row_t s;
        s.prt   = p;
        s.chg   = c;
        s.lvl   = l;
        s.frm   = f;
        s.typed = typed;
        s.want  = want;
        return s;
    endfunction

    // offer one request, hold it until taken, then queue what the record should read
    task automatic send_event(input logic [PORT_W-1:0] p, input logic [MASK_W-1:0] c,
                              input logic [MASK_W-1:0] l, input logic [FRAME_W-1:0] f,
                              input bit typed, input res_t want);
        res_t predicted;
        while (!calm && $urandom_range(99) < 38)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        ev_port    <= p;
        ev_changed <= c;
        ev_pressed <= l;
        ev_frame   <= f;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = predict_event(p, c, l, f);
        expected_records.push_back(typed ? want : predicted);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_records.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_window(input logic [WINDOW_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        window_reg = value;
    endtask

    function automatic logic [FRAME_W-1:0] pick_delta();
        int lim;
        lim = (window_reg < 40) ? int'(window_reg) + 2 : 40;
        if ($urandom_range(3) == 0)
            return FRAME_W'($urandom_range(65535));
        return FRAME_W'($urandom_range(lim));
    endfunction

    // press, release, press, release of one arrow with deltas around the window
    task automatic tap_sequence();
        logic [PORT_W-1:0]  p;
        logic [2:0]         pos;
        logic [MASK_W-1:0]  abit;
        logic [MASK_W-1:0]  extra;
        logic [FRAME_W-1:0] f;
        p     = PORT_W'($urandom_range(TRACKED_PORTS - 1));
        pos   = 3'($urandom_range(3));
        abit  = MASK_W'(1) << pos;
        extra = ($urandom_range(3) == 0) ? (MASK_W'($urandom_range(4095)) & 12'hFF0) : '0;
        f     = FRAME_W'($urandom_range(65535));
        send_event(p, abit | extra, abit | MASK_W'($urandom_range(4095)), f, 1'b0, '0);
        f = f + pick_delta();
        send_event(p, abit, MASK_W'($urandom_range(4095)) & ~abit, f, 1'b0, '0);
        f = f + pick_delta();
        send_event(p, abit, abit | MASK_W'($urandom_range(4095)), f, 1'b0, '0);
        f = f + pick_delta();
        send_event(p, abit | extra, MASK_W'($urandom_range(4095)) & ~abit, f, 1'b0, '0);
    endtask

    task automatic random_burst(input int n_items);
        int                 done_cnt;
        int                 pick;
        logic [FRAME_W-1:0] f;
        done_cnt = 0;
        f = '0;
        while (done_cnt < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 50)
            begin
                tap_sequence();
                done_cnt += 4;
            end
            else if (pick < 70)
            begin
                send_event(PORT_W'($urandom_range(TRACKED_PORTS - 1)),
                           MASK_W'($urandom_range(15) << 4), MASK_W'($urandom_range(255)),
                           FRAME_W'($urandom_range(65535)), 1'b0, '0);
                done_cnt++;
            end
            else if (pick < 85)
            begin
                f = f + pick_delta();
                send_event(PORT_W'($urandom_range(TRACKED_PORTS - 1)),
                           MASK_W'($urandom_range(255)), MASK_W'($urandom_range(255)),
                           f, 1'b0, '0);
                done_cnt++;
            end
            else
            begin
                send_event(PORT_W'($urandom_range(7)), MASK_W'($urandom_range(4095)),
                           MASK_W'($urandom_range(4095)), FRAME_W'($urandom_range(65535)),
                           1'b0, '0);
                done_cnt++;
            end
        end
    endtask

    task automatic check_field(input string name, input logic [FRAME_W-1:0] want,
                               input logic [FRAME_W-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin : record_check
        res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_records.size() == 0)
            begin
                $error("record returned with no request outstanding");
                mismatch_count++;
            end
            else
            begin
                want = expected_records.pop_front();
                check_field("accepted", want.accepted, rec_accepted);
                check_field("held_key_mask", want.held_key_mask, rec_keys);
                check_field("held_arrow_mask", want.held_arrow_mask, rec_arrows);
                check_field("last_arrow_mask", want.last_arrow_mask, rec_last_arrow);
                check_field("double_tap_x", want.double_tap_x, rec_tap_x);
                check_field("double_tap_y", want.double_tap_y, rec_tap_y);
                check_field("key_press_frame", want.key_press_frame, rec_press_frame);
                check_field("key_release_frame", want.key_release_frame, rec_release_frame);
            end
        end
    end

    // result side: random stalls, or one long hold-off when asked
    initial
    begin : record_sink
        int k;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                for (k = 0; k < HOLD_CYCLES; k++)
                    @(posedge clk);
                hold_req = 1'b0;
                out_stall <= 1'b0;
            end
            else
                out_stall <= !calm && ($urandom_range(99) < 38);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        stim_row_t           rows[$];
        logic [WINDOW_W-1:0] windows [6];
        window_reg = WINDOW_RESET;
        for (int p = 0; p < TRACKED_PORTS; p++)
        begin
            keys_st[p]        = '0;
            arrows_st[p]      = '0;
            last_rel_st[p]    = '0;
            key_press_st[p]   = '0;
            key_release_st[p] = '0;
            arr_press_st[p]   = '0;
            arr_release_st[p] = '0;
            flags_st[p]       = '0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fresh records, untracked ports, extremes
        rows.push_back(row_of(0, 12'h000, 12'h000, 16'h0000, 1, mk_res(1, 0, 0, 0, 0, 0, 0, 0)));
        rows.push_back(row_of(7, 12'hFFF, 12'hFFF, 16'hFFFF, 1, mk_res(0, 0, 0, 0, 0, 0, 0, 0)));
        rows.push_back(row_of(4, 12'hFFF, 12'h000, 16'h1234, 1, mk_res(0, 0, 0, 0, 0, 0, 0, 0)));
        rows.push_back(row_of(3, 12'h040, 12'h040, 16'hFFFF, 1,
                              mk_res(1, 8'h40, 0, 0, 0, 0, 16'hFFFF, 0)));
        // upper mask bits do nothing, then B and C press while A releases
        rows.push_back(row_of(2, 12'hF00, 12'hF00, 16'h0100, 1, mk_res(1, 0, 0, 0, 0, 0, 0, 0)));
        rows.push_back(row_of(3, 12'h070, 12'h030, 16'h0000, 0, '0));
        // start press wipes the other keys
        rows.push_back(row_of(3, 12'h080, 12'h080, 16'h0005, 1,
                              mk_res(1, 8'h80, 0, 0, 0, 0, 16'h0005, 0)));
        rows.push_back(row_of(3, 12'h080, 12'h000, 16'h0006, 0, '0));
        // left double tap, then release clears it
        rows.push_back(row_of(0, 12'h004, 12'h004, 16'd100, 0, '0));
        rows.push_back(row_of(0, 12'h004, 12'h000, 16'd110, 0, '0));
        rows.push_back(row_of(0, 12'h004, 12'h004, 16'd120, 0, '0));
        rows.push_back(row_of(0, 12'h004, 12'h000, 16'd125, 0, '0));
        // up double tap across the frame wrap
        rows.push_back(row_of(1, 12'h001, 12'h001, 16'd65530, 0, '0));
        rows.push_back(row_of(1, 12'h001, 12'h000, 16'd3, 0, '0));
        rows.push_back(row_of(1, 12'h001, 12'h001, 16'd10, 0, '0));
        rows.push_back(row_of(1, 12'h003, 12'h002, 16'd12, 0, '0));
        // hold exactly at the window, then gap exactly at the window
        rows.push_back(row_of(2, 12'h008, 12'h008, 16'd0, 0, '0));
        rows.push_back(row_of(2, 12'h008, 12'h000, 16'd30, 0, '0));
        rows.push_back(row_of(2, 12'h008, 12'h008, 16'd31, 0, '0));
        rows.push_back(row_of(2, 12'h008, 12'h000, 16'd40, 0, '0));
        rows.push_back(row_of(2, 12'h008, 12'h008, 16'd70, 0, '0));
        // a different arrow than the last one released
        rows.push_back(row_of(0, 12'h008, 12'h008, 16'd126, 0, '0));
        rows.push_back(row_of(1, 12'h0FF, 12'h0FF, 16'hFFFF, 0, '0));
        rows.push_back(row_of(1, 12'h0FF, 12'h000, 16'h0000, 0, '0));

        foreach (rows[i])
            send_event(rows[i].prt, rows[i].chg, rows[i].lvl, rows[i].frm,
                       rows[i].typed, rows[i].want);
        drain_results();

        windows = '{16'd1, 16'd0, 16'hFFFF, WINDOW_RESET, 16'($urandom_range(2, 200)), 16'd12};
        for (int ph = 0; ph < 6; ph++)
        begin
            write_window(windows[ph]);
            if (ph == 2)
                hold_req = 1'b1;
            calm = (ph == 3);
            random_burst(230);
            calm = 1'b0;
            drain_results();
        end

        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
